// ===== hw/rtl/dcmb_pkg.sv =====
// Shared types and constants for the dual CPU mailbox and interrupt ports.
// Holds no logic of its own; used by dcmb_core and dual_cpu_mailbox_irq_ports.

package dcmb_pkg;

  // Kind of item presented on the input stream
  typedef enum logic [2:0] {
    ACT_MAIN_WR = 3'd0,
    ACT_MAIN_RD = 3'd1,
    ACT_SUB_WR  = 3'd2,
    ACT_SUB_RD  = 3'd3,
    ACT_TICK    = 3'd4
  } action_e;

  // Configuration register indexes
  localparam logic [7:0] CFG_SUB_DIP  = 8'd0;
  localparam logic [7:0] CFG_ALT_COIN = 8'd1;

  // Main bus decode, exact addresses
  localparam logic [15:0] MAIN_MBOX_RD  = 16'h1000;
  localparam logic [15:0] MAIN_STATUS   = 16'h1200;
  localparam logic [15:0] MAIN_CTRL     = 16'h1600;
  localparam logic [15:0] MAIN_VGO      = 16'h1640;
  localparam logic [15:0] MAIN_WDOG     = 16'h1680;
  localparam logic [15:0] MAIN_VRST     = 16'h16c0;
  localparam logic [15:0] MAIN_IRQ_CLR  = 16'h1700;
  localparam logic [15:0] MAIN_ROM_BANK = 16'h1740;
  localparam logic [15:0] MAIN_RAM_BANK = 16'h1780;
  localparam logic [15:0] MAIN_MBOX_WR  = 16'h17c0;

  // Sub bus decode, by 2 KiB region
  localparam logic [15:0] SUB_REGION_MASK = 16'hf800;
  localparam logic [15:0] SUB_SOUND       = 16'h2000;
  localparam logic [15:0] SUB_STATUS      = 16'h2800;
  localparam logic [15:0] SUB_MBOX_RD     = 16'h3000;
  localparam logic [15:0] SUB_DIP_IRQ     = 16'h4000;
  localparam logic [15:0] SUB_MBOX_WR     = 16'h5000;

  // Switch masks
  localparam logic [7:0] MAIN_SW_MASK = 8'h30;
  localparam logic [7:0] SUB_SW_MASK  = 8'hfc;

  // One input item
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic        vector_done;
    logic        timing_bit;
    logic [7:0]  main_switches;
    logic [7:0]  sub_switches;
    logic [1:0]  coin_switches;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       main_irq;
    logic       sub_irq;
    logic       sub_nmi_pulse;
    logic       sub_halted;
    logic       sub_reset_pulse;
    logic       vector_go;
    logic       vec_rst_pulse;
    logic       watchdog_kick;
    logic [1:0] rom_bank;
    logic       ram_bank;
    logic       sound_access;
  } result_t;

endpackage

// ===== hw/rtl/dcmb_core.sv =====
// Mailbox latches, handshake flags, bank and control registers, IRQ counters.
// Decodes one item per cycle when an item is taken (fire_i high); depends on dcmb_pkg.

module dcmb_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  dcmb_pkg::item_t  item_i,
  input  logic [7:0]       sub_dip_i,
  input  logic [1:0]       alt_coin_i,
  output dcmb_pkg::result_t result_o
);

  logic [7:0] to_sub_q, to_sub_d;
  logic [7:0] to_main_q, to_main_d;
  logic       main_sent_q, main_sent_d;
  logic       main_got_q, main_got_d;
  logic       sub_sent_q, sub_sent_d;
  logic       sub_got_q, sub_got_d;
  logic       player_sel_q, player_sel_d;
  logic [3:0] main_cnt_q, main_cnt_d;
  logic       main_armed_q, main_armed_d;
  logic [3:0] sub_cnt_q, sub_cnt_d;
  logic       main_line_q, main_line_d;
  logic       sub_line_q, sub_line_d;
  logic       halt_q, halt_d;
  logic [1:0] rom_bank_q, rom_bank_d;
  logic       ram_bank_q, ram_bank_d;

  logic [15:0] region;
  logic [3:0]  main_cnt_inc;
  logic [3:0]  sub_cnt_inc;
  logic [1:0]  coin_sel;

  assign region       = item_i.address & dcmb_pkg::SUB_REGION_MASK;
  assign main_cnt_inc = main_cnt_q + 4'd1;
  assign sub_cnt_inc  = sub_cnt_q + 4'd1;
  assign coin_sel     = player_sel_q ? alt_coin_i : item_i.coin_switches;

  // Decode of one item: next state and the result it reports
  always_comb begin
    to_sub_d     = to_sub_q;
    to_main_d    = to_main_q;
    main_sent_d  = main_sent_q;
    main_got_d   = main_got_q;
    sub_sent_d   = sub_sent_q;
    sub_got_d    = sub_got_q;
    player_sel_d = player_sel_q;
    main_cnt_d   = main_cnt_q;
    main_armed_d = main_armed_q;
    sub_cnt_d    = sub_cnt_q;
    main_line_d  = main_line_q;
    sub_line_d   = sub_line_q;
    halt_d       = halt_q;
    rom_bank_d   = rom_bank_q;
    ram_bank_d   = ram_bank_q;
    result_o     = '0;

    case (dcmb_pkg::action_e'(item_i.action))
      dcmb_pkg::ACT_MAIN_WR: begin
        case (item_i.address)
          dcmb_pkg::MAIN_CTRL: begin
            player_sel_d = item_i.data[5];
            halt_d       = ~item_i.data[3];
            if (!item_i.data[3]) begin
              result_o.sub_reset_pulse = 1'b1;
              main_sent_d = 1'b0;
              main_got_d  = 1'b0;
              sub_sent_d  = 1'b0;
              sub_got_d   = 1'b0;
            end
          end
          dcmb_pkg::MAIN_VGO:  result_o.vector_go     = 1'b1;
          dcmb_pkg::MAIN_WDOG: result_o.watchdog_kick = 1'b1;
          dcmb_pkg::MAIN_VRST: result_o.vec_rst_pulse = 1'b1;
          dcmb_pkg::MAIN_IRQ_CLR: begin
            main_line_d  = 1'b0;
            main_cnt_d   = 4'd0;
            main_armed_d = 1'b1;
          end
          dcmb_pkg::MAIN_ROM_BANK: rom_bank_d = item_i.data[1:0];
          dcmb_pkg::MAIN_RAM_BANK: ram_bank_d = item_i.data[0];
          dcmb_pkg::MAIN_MBOX_WR: begin
            sub_got_d   = 1'b0;
            main_sent_d = 1'b1;
            to_sub_d    = item_i.data;
            result_o.sub_nmi_pulse = 1'b1;
          end
          default: ;
        endcase
      end
      dcmb_pkg::ACT_MAIN_RD: begin
        if (item_i.address == dcmb_pkg::MAIN_MBOX_RD) begin
          main_got_d = 1'b1;
          sub_sent_d = 1'b0;
          result_o.read_data = to_main_q;
        end else if (item_i.address == dcmb_pkg::MAIN_STATUS) begin
          result_o.read_data = (item_i.main_switches & dcmb_pkg::MAIN_SW_MASK)
                             | {coin_sel, 2'b00, sub_got_q, sub_sent_q,
                                ~item_i.timing_bit, item_i.vector_done};
        end
      end
      dcmb_pkg::ACT_SUB_WR: begin
        if (region == dcmb_pkg::SUB_SOUND) begin
          result_o.sound_access = 1'b1;
        end else if (region == dcmb_pkg::SUB_DIP_IRQ) begin
          sub_line_d = 1'b0;
          sub_cnt_d  = 4'd0;
        end else if (region == dcmb_pkg::SUB_MBOX_WR) begin
          main_got_d = 1'b0;
          sub_sent_d = 1'b1;
          to_main_d  = item_i.data;
        end
      end
      dcmb_pkg::ACT_SUB_RD: begin
        if (region == dcmb_pkg::SUB_SOUND) begin
          result_o.sound_access = 1'b1;
        end else if (region == dcmb_pkg::SUB_STATUS) begin
          result_o.read_data = (item_i.sub_switches & dcmb_pkg::SUB_SW_MASK)
                             | {6'd0, main_got_q, main_sent_q};
        end else if (region == dcmb_pkg::SUB_MBOX_RD) begin
          sub_got_d   = 1'b1;
          main_sent_d = 1'b0;
          result_o.read_data = to_sub_q;
        end else if (region == dcmb_pkg::SUB_DIP_IRQ) begin
          result_o.read_data = sub_dip_i;
        end
      end
      dcmb_pkg::ACT_TICK: begin
        // Main counter fires once when bits 3:2 are both set, then stops
        if (main_armed_q) begin
          main_cnt_d = main_cnt_inc;
          if (main_cnt_inc[3:2] == 2'b11) begin
            main_line_d  = 1'b1;
            main_armed_d = 1'b0;
          end
        end
        sub_cnt_d  = sub_cnt_inc;
        sub_line_d = sub_cnt_inc[3];
      end
      default: ;
    endcase

    result_o.main_irq   = main_line_d;
    result_o.sub_irq    = sub_line_d;
    result_o.sub_halted = halt_d;
    result_o.rom_bank   = rom_bank_d;
    result_o.ram_bank   = ram_bank_d;
  end

  // State registers, updated only when an item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_sub_q     <= 8'd0;
      to_main_q    <= 8'd0;
      main_sent_q  <= 1'b0;
      main_got_q   <= 1'b0;
      sub_sent_q   <= 1'b1;
      sub_got_q    <= 1'b0;
      player_sel_q <= 1'b0;
      main_cnt_q   <= 4'd0;
      main_armed_q <= 1'b1;
      sub_cnt_q    <= 4'd0;
      main_line_q  <= 1'b0;
      sub_line_q   <= 1'b0;
      halt_q       <= 1'b0;
      rom_bank_q   <= 2'd0;
      ram_bank_q   <= 1'b0;
    end else if (fire_i) begin
      to_sub_q     <= to_sub_d;
      to_main_q    <= to_main_d;
      main_sent_q  <= main_sent_d;
      main_got_q   <= main_got_d;
      sub_sent_q   <= sub_sent_d;
      sub_got_q    <= sub_got_d;
      player_sel_q <= player_sel_d;
      main_cnt_q   <= main_cnt_d;
      main_armed_q <= main_armed_d;
      sub_cnt_q    <= sub_cnt_d;
      main_line_q  <= main_line_d;
      sub_line_q   <= sub_line_d;
      halt_q       <= halt_d;
      rom_bank_q   <= rom_bank_d;
      ram_bank_q   <= ram_bank_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The main interrupt is either pending or the counter is armed, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(main_armed_q && main_line_q))
    else $error("main irq armed while line asserted");

  // The sub interrupt line always mirrors bit 3 of its counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_line_q == sub_cnt_q[3])
    else $error("sub irq line out of step with counter");

  // A sub reset through the control port clears all four handshake flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == dcmb_pkg::ACT_MAIN_WR
     && item_i.address == dcmb_pkg::MAIN_CTRL && !item_i.data[3])
    |=> (!main_sent_q && !main_got_q && !sub_sent_q && !sub_got_q && halt_q))
    else $error("sub reset left a flag set");

  // Without an item the mailbox state does not move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(to_sub_q) && $stable(to_main_q) && $stable(main_cnt_q)
                 && $stable(sub_cnt_q) && $stable(main_sent_q) && $stable(sub_sent_q)))
    else $error("state changed without an item");
`endif

endmodule

// ===== hw/rtl/dual_cpu_mailbox_irq_ports.sv =====
// Top level of the dual CPU mailbox and interrupt ports.
// Depends on dcmb_pkg and instantiates dcmb_core.
//
// Usage:
//   Input stream (s_axis_*): one item per bus access or interrupt tick; the
//   kind of item travels in tuser, the access fields in tdata.
//   Output stream (m_axis_*): exactly one result item for every input item,
//   in order.
//   Configuration channel (cfg_*): writes the switch byte (index 0) and the
//   alternate coin bits (index 1); always ready, other indexes are ignored.
// Pipeline:
//   An accepted item is registered in the input register, decoded by
//   one level of flag and latch logic, and its result is loaded into the
//   output register. One item per cycle is sustained while the receiver
//   keeps m_axis_tready high; the state update of one item is ready
//   for the next item in the following cycle.
// Reset and stalls:
//   Reset empties both registers and loads the mailbox state and the
//   configuration registers with their reset values. When the receiver
//   holds m_axis_tready low, the result waits in the output register, one
//   further item waits in the input register, and s_axis_tready drops.

module dual_cpu_mailbox_irq_ports (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bit up: address[15:0], data[23:16], vector_done[24],
  // timing_bit[25], main_switches[33:26], sub_switches[41:34],
  // coin_switches[43:42], zero fill[47:44]
  input  logic [47:0] s_axis_tdata,
  // tuser: action[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bit up: read_data[7:0], main_irq[8], sub_irq[9],
  // sub_nmi_pulse[10], sub_halted[11], sub_reset_pulse[12], vector_go[13],
  // vec_rst_pulse[14], watchdog_kick[15], rom_bank[17:16], ram_bank[18],
  // sound_access[19], zero fill[23:20]
  output logic [23:0] m_axis_tdata,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic              in_valid_q;
  dcmb_pkg::item_t   in_item_q;
  dcmb_pkg::item_t   in_item_d;
  logic              out_valid_q;
  dcmb_pkg::result_t out_res_q;
  dcmb_pkg::result_t core_res;
  logic              advance;
  logic              fire;
  logic [7:0]        sub_dip_q;
  logic [1:0]        alt_coin_q;

  // Unpack the incoming item
  always_comb begin
    in_item_d.action        = s_axis_tuser;
    in_item_d.address       = s_axis_tdata[15:0];
    in_item_d.data          = s_axis_tdata[23:16];
    in_item_d.vector_done   = s_axis_tdata[24];
    in_item_d.timing_bit    = s_axis_tdata[25];
    in_item_d.main_switches = s_axis_tdata[33:26];
    in_item_d.sub_switches  = s_axis_tdata[41:34];
    in_item_d.coin_switches = s_axis_tdata[43:42];
  end

  // Handshake: the decode stage moves when the output register is free
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_dip_q  <= 8'hff;
      alt_coin_q <= 2'd3;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dcmb_pkg::CFG_SUB_DIP) begin
        sub_dip_q <= cfg_data_i;
      end else if (cfg_index_i == dcmb_pkg::CFG_ALT_COIN) begin
        alt_coin_q <= cfg_data_i[1:0];
      end
    end
  end

  dcmb_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_q),
    .sub_dip_i  (sub_dip_q),
    .alt_coin_i (alt_coin_q),
    .result_o   (core_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  // Pack the result item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0,
                          out_res_q.sound_access,
                          out_res_q.ram_bank,
                          out_res_q.rom_bank,
                          out_res_q.watchdog_kick,
                          out_res_q.vec_rst_pulse,
                          out_res_q.vector_go,
                          out_res_q.sub_reset_pulse,
                          out_res_q.sub_halted,
                          out_res_q.sub_nmi_pulse,
                          out_res_q.sub_irq,
                          out_res_q.main_irq,
                          out_res_q.read_data};

endmodule

// ===== tb/sv/dual_cpu_mailbox_irq_ports_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dual_cpu_mailbox_irq_ports: drives bus accesses and ticks,
// predicts every result item and compares it field by field. Depends on dcmb_pkg and the design.

module dual_cpu_mailbox_irq_ports_tb;

  localparam real     CLK_PERIOD   = 12.0;
  localparam realtime RUN_LIMIT    = 2_000_000ns;
  localparam logic [7:0]  CFG_SPARE     = 8'hff;
  localparam logic [2:0]  ACT_SPARE_MIN = 3'd5;
  localparam logic [2:0]  ACT_SPARE_MAX = 3'd7;
  localparam logic [15:0] SUB_SPARE     = 16'h4800;
  localparam logic [15:0] SUB_SOUND_TOP = 16'h27ff;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  dual_cpu_mailbox_irq_ports dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted state of the mailboxes, flags, counters and banks.
  logic [7:0] cfg_sub_dip;
  logic [1:0] cfg_alt_coin;
  logic [7:0] mb_to_sub, mb_to_main;
  logic       main_sent, main_got, sub_sent, sub_got;
  logic       player_sel, main_armed, main_irq_q, sub_irq_q, halted;
  logic [3:0] main_cnt, sub_cnt;
  logic [1:0] rom_bank_q;
  logic       ram_bank_q;

  dcmb_pkg::result_t due_results[$];
  int      err_count = 0;
  int      idle_pct  = 30;
  int      stall_pct = 30;
  int      hold_left = 0;
  dcmb_pkg::result_t got_res, exp_res;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic reset_prediction();
    cfg_sub_dip  = 8'hff;
    cfg_alt_coin = 2'd3;
    mb_to_sub    = '0;
    mb_to_main   = '0;
    main_sent    = 1'b0;
    main_got     = 1'b0;
    sub_sent     = 1'b1;
    sub_got      = 1'b0;
    player_sel   = 1'b0;
    main_cnt     = '0;
    main_armed   = 1'b1;
    sub_cnt      = '0;
    main_irq_q   = 1'b0;
    sub_irq_q    = 1'b0;
    halted       = 1'b0;
    rom_bank_q   = '0;
    ram_bank_q   = 1'b0;
  endtask

  // Works out the result of one accepted item and advances the predicted state.
  function automatic dcmb_pkg::result_t predict_ports(input dcmb_pkg::item_t it);
    dcmb_pkg::result_t r;
    logic [15:0]       region;
    r      = '0;
    region = it.address & dcmb_pkg::SUB_REGION_MASK;
    case (it.action)
      dcmb_pkg::ACT_MAIN_WR: begin
        case (it.address)
          dcmb_pkg::MAIN_CTRL: begin
            player_sel = it.data[5];
            if (!it.data[3]) begin
              r.sub_reset_pulse = 1'b1;
              main_sent = 1'b0;
              main_got  = 1'b0;
              sub_sent  = 1'b0;
              sub_got   = 1'b0;
            end
            halted = ~it.data[3];
          end
          dcmb_pkg::MAIN_VGO:  r.vector_go     = 1'b1;
          dcmb_pkg::MAIN_WDOG: r.watchdog_kick = 1'b1;
          dcmb_pkg::MAIN_VRST: r.vec_rst_pulse = 1'b1;
          dcmb_pkg::MAIN_IRQ_CLR: begin
            main_irq_q = 1'b0;
            main_cnt   = '0;
            main_armed = 1'b1;
          end
          dcmb_pkg::MAIN_ROM_BANK: rom_bank_q = it.data[1:0];
          dcmb_pkg::MAIN_RAM_BANK: ram_bank_q = it.data[0];
          dcmb_pkg::MAIN_MBOX_WR: begin
            sub_got         = 1'b0;
            main_sent       = 1'b1;
            mb_to_sub       = it.data;
            r.sub_nmi_pulse = 1'b1;
          end
          default: ;
        endcase
      end
      dcmb_pkg::ACT_MAIN_RD: begin
        if (it.address == dcmb_pkg::MAIN_MBOX_RD) begin
          main_got    = 1'b1;
          sub_sent    = 1'b0;
          r.read_data = mb_to_main;
        end else if (it.address == dcmb_pkg::MAIN_STATUS) begin
          r.read_data = {player_sel ? cfg_alt_coin : it.coin_switches,
                         it.main_switches[5:4], sub_got, sub_sent,
                         ~it.timing_bit, it.vector_done};
        end
      end
      dcmb_pkg::ACT_SUB_WR: begin
        if (region == dcmb_pkg::SUB_SOUND) begin
          r.sound_access = 1'b1;
        end else if (region == dcmb_pkg::SUB_DIP_IRQ) begin
          sub_irq_q = 1'b0;
          sub_cnt   = '0;
        end else if (region == dcmb_pkg::SUB_MBOX_WR) begin
          main_got   = 1'b0;
          sub_sent   = 1'b1;
          mb_to_main = it.data;
        end
      end
      dcmb_pkg::ACT_SUB_RD: begin
        if (region == dcmb_pkg::SUB_SOUND) begin
          r.sound_access = 1'b1;
        end else if (region == dcmb_pkg::SUB_STATUS) begin
          r.read_data = {it.sub_switches[7:2], main_got, main_sent};
        end else if (region == dcmb_pkg::SUB_MBOX_RD) begin
          sub_got     = 1'b1;
          main_sent   = 1'b0;
          r.read_data = mb_to_sub;
        end else if (region == dcmb_pkg::SUB_DIP_IRQ) begin
          r.read_data = cfg_sub_dip;
        end
      end
      dcmb_pkg::ACT_TICK: begin
        if (main_armed) begin
          main_cnt = main_cnt + 4'd1;
          if (main_cnt[3:2] == 2'b11) begin
            main_irq_q = 1'b1;
            main_armed = 1'b0;
          end
        end
        sub_cnt   = sub_cnt + 4'd1;
        sub_irq_q = sub_cnt[3];
      end
      default: ;
    endcase
    r.main_irq   = main_irq_q;
    r.sub_irq    = sub_irq_q;
    r.sub_halted = halted;
    r.rom_bank   = rom_bank_q;
    r.ram_bank   = ram_bank_q;
    return r;
  endfunction

  // An access with the given kind, address and data; the switch inputs are random.
  function automatic dcmb_pkg::item_t make_item(input logic [2:0] act,
                                                input logic [15:0] addr,
                                                input logic [7:0] dat);
    dcmb_pkg::item_t it;
    it.action        = act;
    it.address       = addr;
    it.data          = dat;
    it.vector_done   = 1'($urandom_range(1));
    it.timing_bit    = 1'($urandom_range(1));
    it.main_switches = 8'($urandom_range(255));
    it.sub_switches  = 8'($urandom_range(255));
    it.coin_switches = 2'($urandom_range(3));
    return it;
  endfunction

  // Mostly decoded addresses, with some fully random ones and spare action codes.
  function automatic dcmb_pkg::item_t random_item();
    int          pick;
    logic [2:0]  act;
    logic [15:0] addr;
    pick = $urandom_range(99);
    addr = 16'($urandom_range(16'hffff));
    if (pick < 28) begin
      act = dcmb_pkg::ACT_MAIN_WR;
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(8))
          0: addr = dcmb_pkg::MAIN_CTRL;
          1: addr = dcmb_pkg::MAIN_VGO;
          2: addr = dcmb_pkg::MAIN_WDOG;
          3: addr = dcmb_pkg::MAIN_VRST;
          4: addr = ($urandom_range(3) == 0) ? dcmb_pkg::MAIN_IRQ_CLR
                                             : dcmb_pkg::MAIN_MBOX_WR;
          5: addr = dcmb_pkg::MAIN_ROM_BANK;
          6: addr = dcmb_pkg::MAIN_RAM_BANK;
          7: addr = dcmb_pkg::MAIN_MBOX_WR;
          default: addr = dcmb_pkg::MAIN_STATUS;
        endcase
      end
    end else if (pick < 42) begin
      act = dcmb_pkg::ACT_MAIN_RD;
      if ($urandom_range(99) < 80)
        addr = ($urandom_range(1) == 0) ? dcmb_pkg::MAIN_MBOX_RD : dcmb_pkg::MAIN_STATUS;
    end else if (pick < 74) begin
      act = (pick < 58) ? dcmb_pkg::ACT_SUB_WR : dcmb_pkg::ACT_SUB_RD;
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(5))
          0: addr = dcmb_pkg::SUB_SOUND;
          1: addr = dcmb_pkg::SUB_STATUS;
          2: addr = dcmb_pkg::SUB_MBOX_RD;
          3: addr = dcmb_pkg::SUB_DIP_IRQ;
          4: addr = SUB_SPARE;
          default: addr = dcmb_pkg::SUB_MBOX_WR;
        endcase
        addr = addr | 16'($urandom_range(11'h7ff));
      end
    end else if (pick < 96) begin
      act = dcmb_pkg::ACT_TICK;
    end else begin
      act = 3'($urandom_range(ACT_SPARE_MAX, ACT_SPARE_MIN));
    end
    return make_item(act, addr, 8'($urandom_range(255)));
  endfunction

  // Offers one item, with a random gap first, and records its expected result once
  // accepted. The valid line stays high on return so that back-to-back items need no
  // second assignment in the same time step.
  task automatic send_access(input dcmb_pkg::item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {4'b0, it.coin_switches, it.sub_switches, it.main_switches,
                      it.timing_bit, it.vector_done, it.data, it.address};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    due_results.push_back(predict_ports(it));
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (due_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == dcmb_pkg::CFG_SUB_DIP) cfg_sub_dip = val;
    else if (idx == dcmb_pkg::CFG_ALT_COIN) cfg_alt_coin = val[1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Changes both registers with the block idle.
  task automatic set_config(input logic [7:0] dip, input logic [1:0] alt);
    wait_drained();
    repeat (3) @(negedge clk_i);
    cfg_write(dcmb_pkg::CFG_SUB_DIP, dip);
    cfg_write(dcmb_pkg::CFG_ALT_COIN, {6'b0, alt});
  endtask

  // A full exchange: main posts a byte, sub polls and takes it, sub answers and main
  // polls and takes the answer.
  task automatic mailbox_round_trip(input logic [7:0] to_sub, input logic [7:0] to_main);
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_MBOX_WR, to_sub));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD,
                          dcmb_pkg::SUB_STATUS | 16'($urandom_range(11'h7ff)), 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD,
                          dcmb_pkg::SUB_MBOX_RD | 16'($urandom_range(11'h7ff)), 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_WR,
                          dcmb_pkg::SUB_MBOX_WR | 16'($urandom_range(11'h7ff)), to_main));
    send_access(make_item(dcmb_pkg::ACT_MAIN_RD, dcmb_pkg::MAIN_STATUS, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_RD, dcmb_pkg::MAIN_MBOX_RD, 8'h00));
  endtask

  task automatic random_traffic(input int count);
    int done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 25) begin
        mailbox_round_trip(8'($urandom_range(255)), 8'($urandom_range(255)));
        done += 6;
      end else begin
        send_access(random_item());
        done++;
      end
    end
  endtask

  // Status ports and the switch byte straight after reset.
  task automatic test_power_on_status();
    send_access(make_item(dcmb_pkg::ACT_MAIN_RD, dcmb_pkg::MAIN_STATUS, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD, dcmb_pkg::SUB_STATUS, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD, dcmb_pkg::SUB_DIP_IRQ, 8'h00));
  endtask

  // Mailbox transfers with the extreme data bytes.
  task automatic test_mailbox_exchange();
    mailbox_round_trip(8'hff, 8'h00);
  endtask

  // Control port with and without the sub reset, pulse lines, banks and dead writes.
  task automatic test_control_writes();
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_CTRL, 8'h20));
    send_access(make_item(dcmb_pkg::ACT_MAIN_RD, dcmb_pkg::MAIN_STATUS, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_CTRL, 8'h08));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_VGO, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_WDOG, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_VRST, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_ROM_BANK, 8'hff));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_RAM_BANK, 8'hff));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_STATUS, 8'hff));
  endtask

  // Sound range at both ends, a spare sub region and a spare action code.
  task automatic test_sub_decode();
    send_access(make_item(dcmb_pkg::ACT_SUB_WR, dcmb_pkg::SUB_SOUND, 8'hff));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD, SUB_SOUND_TOP, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_RD, SUB_SPARE, 8'h00));
    send_access(make_item(ACT_SPARE_MIN, 16'hffff, 8'hff));
  endtask

  // Twelve ticks raise both lines; then each is cleared by its own write.
  task automatic test_irq_counters();
    repeat (12) send_access(make_item(dcmb_pkg::ACT_TICK, 16'h0000, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_MAIN_WR, dcmb_pkg::MAIN_IRQ_CLR, 8'h00));
    send_access(make_item(dcmb_pkg::ACT_SUB_WR, dcmb_pkg::SUB_DIP_IRQ, 8'h00));
  endtask

  // The receiver holds off while items keep coming, so the input side stalls; the
  // sender then waits for every result before going on.
  task automatic test_backpressure();
    hold_left = 60;
    random_traffic(24);
    wait_drained();
  endtask

  // A stretch at full rate with neither side idling.
  task automatic test_full_rate();
    idle_pct  = 0;
    stall_pct = 0;
    random_traffic(150);
    idle_pct  = 30;
    stall_pct = 30;
  endtask

  // Extreme and random register settings, and a write to an unused index.
  task automatic test_config_settings();
    set_config(8'h00, 2'd0);
    random_traffic(180);
    set_config(8'($urandom_range(255)), 2'($urandom_range(3)));
    cfg_write(CFG_SPARE, 8'h00);
    random_traffic(180);
    set_config(8'hff, 2'd3);
    random_traffic(180);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_pct == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      err_count++;
    end
  endtask

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.read_data       = m_axis_tdata[7:0];
      got_res.main_irq        = m_axis_tdata[8];
      got_res.sub_irq         = m_axis_tdata[9];
      got_res.sub_nmi_pulse   = m_axis_tdata[10];
      got_res.sub_halted      = m_axis_tdata[11];
      got_res.sub_reset_pulse = m_axis_tdata[12];
      got_res.vector_go       = m_axis_tdata[13];
      got_res.vec_rst_pulse   = m_axis_tdata[14];
      got_res.watchdog_kick   = m_axis_tdata[15];
      got_res.rom_bank        = m_axis_tdata[17:16];
      got_res.ram_bank        = m_axis_tdata[18];
      got_res.sound_access    = m_axis_tdata[19];
      if (due_results.size() == 0) begin
        $error("result item %06h arrived with nothing expected", m_axis_tdata);
        err_count++;
      end else begin
        exp_res = due_results.pop_front();
        compare_field("read_data", exp_res.read_data, got_res.read_data);
        compare_field("main_irq", exp_res.main_irq, got_res.main_irq);
        compare_field("sub_irq", exp_res.sub_irq, got_res.sub_irq);
        compare_field("sub_nmi_pulse", exp_res.sub_nmi_pulse, got_res.sub_nmi_pulse);
        compare_field("sub_halted", exp_res.sub_halted, got_res.sub_halted);
        compare_field("sub_reset_pulse", exp_res.sub_reset_pulse, got_res.sub_reset_pulse);
        compare_field("vector_go", exp_res.vector_go, got_res.vector_go);
        compare_field("vec_rst_pulse", exp_res.vec_rst_pulse, got_res.vec_rst_pulse);
        compare_field("watchdog_kick", exp_res.watchdog_kick, got_res.watchdog_kick);
        compare_field("rom_bank", exp_res.rom_bank, got_res.rom_bank);
        compare_field("ram_bank", exp_res.ram_bank, got_res.ram_bank);
        compare_field("sound_access", exp_res.sound_access, got_res.sound_access);
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    reset_prediction();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_power_on_status();
    test_mailbox_exchange();
    test_control_writes();
    test_sub_decode();
    test_irq_counters();
    random_traffic(230);
    test_backpressure();
    test_full_rate();
    test_config_settings();

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
